// ===== hw/rtl/tlpq_pkg.sv =====
// Shared types, codes and constants of the three-level priority queue.
package tlpq_pkg;

    localparam int NUM_ENTRIES_DEFAULT = 256;
    localparam int ID_W  = 8;
    localparam int OP_W  = 3;
    localparam int LVL_W = 2;
    localparam int ST_W  = 3;
    localparam int NUM_LEVELS = 3;

    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd1;
    localparam logic [OP_W-1:0] OP_NEXT     = 3'd2;
    localparam logic [OP_W-1:0] OP_DEMOTE   = 3'd3;
    localparam logic [OP_W-1:0] OP_RECOVERD = 3'd4;

    localparam logic [ST_W-1:0] STS_OK        = 3'd0;
    localparam logic [ST_W-1:0] STS_DUPLICATE = 3'd1;
    localparam logic [ST_W-1:0] STS_BAD_LEVEL = 3'd2;
    localparam logic [ST_W-1:0] STS_UNKNOWN   = 3'd3;
    localparam logic [ST_W-1:0] STS_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_LOOK,
        SEQ_LINK,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic              valid;
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   result_id;
        logic [LVL_W-1:0]  result_level;
        logic              recovered_flag;
    } res_t;

endpackage

// ===== hw/rtl/tlpq_ram.sv =====
// Simple dual-port synchronous RAM with registered read.
module tlpq_ram
    import tlpq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = NUM_ENTRIES_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tlpq_seq.sv =====
// Operation sequencer: level heads and tails, and read-modify-write of the link stores.
module tlpq_seq
    import tlpq_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT,
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [ID_W-1:0]   in_id,
    input  logic [LVL_W-1:0]  in_level,
    input  logic              out_free,
    output res_t              res,
    // entry state store: {recovered, level}
    output logic              st_we,
    output logic [IW-1:0]     st_waddr,
    output logic [2:0]        st_wdata,
    input  logic [2:0]        st_rdata,
    output logic              nx_we,
    output logic [IW-1:0]     nx_waddr,
    output logic [IW-1:0]     nx_wdata,
    input  logic [IW-1:0]     nx_rdata,
    output logic              pv_we,
    output logic [IW-1:0]     pv_waddr,
    output logic [IW-1:0]     pv_wdata,
    input  logic [IW-1:0]     pv_rdata,
    output logic [IW-1:0]     rd_addr
);

    seq_state_t state_reg, state_next;

    logic [OP_W-1:0]  op_reg, op_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             idok_reg, idok_next;
    logic [LVL_W-1:0] nl_reg, nl_next;
    logic [LVL_W-1:0] top_lv_reg, top_lv_next;
    logic [IW-1:0]    head_reg [NUM_LEVELS];
    logic [IW-1:0]    head_next [NUM_LEVELS];
    logic [IW-1:0]    tail_reg [NUM_LEVELS];
    logic [IW-1:0]    tail_next [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] ne_reg, ne_next;
    logic [IW-1:0]    psh_head_reg, psh_head_next;
    logic [IW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [ST_W-1:0]  rs_status_reg, rs_status_next;
    logic [ID_W-1:0]  rs_id_reg, rs_id_next;
    logic [LVL_W-1:0] rs_level_reg, rs_level_next;
    logic             rs_flag_reg, rs_flag_next;

    logic             link_go;
    logic [LVL_W-1:0] cur_lv, low_lv, uq, lq;
    logic             rec, is_head, is_tail, do_unlink;
    logic [LVL_W-1:0] in_top;

    assign in_ready = (state_reg == SEQ_IDLE);
    assign in_top = ne_reg[2] ? 2'd3 : (ne_reg[1] ? 2'd2 : (ne_reg[0] ? 2'd1 : 2'd0));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_CLEAR: begin
                if (clr_cnt_reg == IW'(NUM_ENTRIES - 1)) state_next = SEQ_IDLE;
            end
            SEQ_IDLE: begin
                if (in_valid) state_next = SEQ_LOOK;
            end
            SEQ_LOOK: begin
                state_next = link_go ? SEQ_LINK : SEQ_DONE;
            end
            SEQ_LINK: begin
                state_next = SEQ_DONE;
            end
            SEQ_DONE: begin
                if (out_free) state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // Datapath and memory port control.
    always_comb begin
        op_next       = op_reg;
        id_next       = id_reg;
        idx_next      = idx_reg;
        idok_next     = idok_reg;
        nl_next       = nl_reg;
        top_lv_next   = top_lv_reg;
        ne_next       = ne_reg;
        psh_head_next = psh_head_reg;
        clr_cnt_next  = clr_cnt_reg;
        rs_status_next = rs_status_reg;
        rs_id_next    = rs_id_reg;
        rs_level_next = rs_level_reg;
        rs_flag_next  = rs_flag_reg;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
        end
        st_we = 1'b0; st_waddr = idx_reg; st_wdata = '0;
        nx_we = 1'b0; nx_waddr = idx_reg; nx_wdata = idx_reg;
        pv_we = 1'b0; pv_waddr = idx_reg; pv_wdata = idx_reg;
        link_go = 1'b0;
        res = '0;
        rd_addr = idx_reg;

        cur_lv  = (op_reg == OP_NEXT) ? top_lv_reg : st_rdata[1:0];
        rec     = st_rdata[2];
        uq      = cur_lv - 2'd1;
        low_lv  = cur_lv - 2'd1;
        lq      = low_lv - 2'd1;
        is_head = (uq != 2'd3) && (head_reg[uq] == idx_reg);
        is_tail = (uq != 2'd3) && (tail_reg[uq] == idx_reg);
        do_unlink = 1'b0;

        case (state_reg)
            SEQ_CLEAR: begin
                st_we        = 1'b1;
                st_waddr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            SEQ_IDLE: begin
                op_next     = in_op;
                id_next     = in_id;
                nl_next     = in_level;
                idok_next   = (32'(in_id) < 32'(NUM_ENTRIES));
                top_lv_next = in_top;
                if (in_op == OP_NEXT && in_top != 2'd0) begin
                    rd_addr = head_reg[in_top - 2'd1];
                end else begin
                    rd_addr = IW'(in_id);
                end
                if (in_valid) idx_next = rd_addr;
            end
            SEQ_LOOK: begin
                rs_status_next = STS_OK;
                rs_id_next     = id_reg;
                rs_level_next  = '0;
                rs_flag_next   = 1'b0;
                if (op_reg == OP_NEXT) begin
                    if (top_lv_reg == 2'd0) begin
                        rs_status_next = STS_EMPTY;
                        rs_id_next     = '0;
                    end else begin
                        do_unlink     = 1'b1;
                        st_we         = 1'b1;
                        st_wdata      = {rec, 2'd0};
                        rs_id_next    = ID_W'(idx_reg);
                        rs_level_next = top_lv_reg;
                        rs_flag_next  = rec;
                    end
                end else if (op_reg <= OP_RECOVERD) begin
                    if (!idok_reg) begin
                        rs_status_next = STS_UNKNOWN;
                    end else begin
                        rs_flag_next = rec;
                        case (op_reg)
                            OP_ADD: begin
                                if (cur_lv != 2'd0) begin
                                    rs_status_next = STS_DUPLICATE;
                                    rs_level_next  = cur_lv;
                                end else if (nl_reg == 2'd0) begin
                                    rs_status_next = STS_BAD_LEVEL;
                                end else begin
                                    rs_level_next = nl_reg;
                                    st_we    = 1'b1;
                                    st_wdata = {rec, nl_reg};
                                    if (ne_reg[nl_reg - 2'd1]) begin
                                        nx_we    = 1'b1;
                                        nx_waddr = tail_reg[nl_reg - 2'd1];
                                        nx_wdata = idx_reg;
                                        pv_we    = 1'b1;
                                        pv_waddr = idx_reg;
                                        pv_wdata = tail_reg[nl_reg - 2'd1];
                                    end else begin
                                        head_next[nl_reg - 2'd1] = idx_reg;
                                    end
                                    tail_next[nl_reg - 2'd1] = idx_reg;
                                    ne_next[nl_reg - 2'd1]   = 1'b1;
                                end
                            end
                            OP_QUERY: begin
                                if (cur_lv == 2'd0) rs_status_next = STS_UNKNOWN;
                                rs_level_next = cur_lv;
                            end
                            OP_RECOVERD: begin
                                rs_level_next = cur_lv;
                            end
                            OP_DEMOTE: begin
                                if (cur_lv == 2'd0) begin
                                    rs_status_next = STS_UNKNOWN;
                                end else begin
                                    do_unlink     = 1'b1;
                                    rs_level_next = low_lv;
                                    rs_flag_next  = rec | (low_lv == 2'd0);
                                    st_we    = 1'b1;
                                    st_wdata = {rec | (low_lv == 2'd0), low_lv};
                                    if (low_lv != 2'd0) begin
                                        // Front insertion; the link writes follow in the next cycle.
                                        psh_head_next = head_reg[lq];
                                        link_go       = ne_reg[lq];
                                        head_next[lq] = idx_reg;
                                        if (!ne_reg[lq]) tail_next[lq] = idx_reg;
                                        ne_next[lq]   = 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                if (do_unlink) begin
                    if (is_head && is_tail) begin
                        ne_next[uq] = 1'b0;
                    end else begin
                        if (is_head) begin
                            head_next[uq] = nx_rdata;
                        end else begin
                            nx_we    = 1'b1;
                            nx_waddr = pv_rdata;
                            nx_wdata = nx_rdata;
                        end
                        if (is_tail) begin
                            tail_next[uq] = pv_rdata;
                        end else begin
                            pv_we    = 1'b1;
                            pv_waddr = nx_rdata;
                            pv_wdata = pv_rdata;
                        end
                    end
                end
            end
            SEQ_LINK: begin
                pv_we    = 1'b1;
                pv_waddr = psh_head_reg;
                pv_wdata = idx_reg;
                nx_we    = 1'b1;
                nx_waddr = idx_reg;
                nx_wdata = psh_head_reg;
            end
            SEQ_DONE: begin
                res.valid          = out_free;
                res.status         = rs_status_reg;
                res.result_id      = rs_id_reg;
                res.result_level   = rs_level_reg;
                res.recovered_flag = rs_flag_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_CLEAR;
            ne_reg      <= '0;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ne_reg      <= ne_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        idx_reg       <= idx_next;
        idok_reg      <= idok_next;
        nl_reg        <= nl_next;
        top_lv_reg    <= top_lv_next;
        psh_head_reg  <= psh_head_next;
        rs_status_reg <= rs_status_next;
        rs_id_reg     <= rs_id_next;
        rs_level_reg  <= rs_level_next;
        rs_flag_reg   <= rs_flag_next;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            head_reg[i] <= head_next[i];
            tail_reg[i] <= tail_next[i];
        end
    end

endmodule

// ===== hw/rtl/three_level_priority_queue_demote_top.sv =====
// Three-level priority queue with demotion: top level with the link stores and result register.
// A keyed strict-priority queue of three FIFO levels kept as doubly linked lists in
// three synchronous memories (entry state, next link, previous link). Each item is one
// operation and gives one result. An item passes through look-up, read-modify-write and
// result, and a demote that places the entry in front of a non-empty lower level adds a
// link-write step, because the second pair of link writes cannot share the single write
// port of each link memory with the first. After reset a clearing pass zeroes the entry
// state store, during which no item is taken. A finished result waits in an output
// register while the next item is accepted; while that register is still full and not
// taken, the sequencer holds in its result cycle and takes no new item.
module three_level_priority_queue_demote_top
    import tlpq_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], entry_id[10:3], new_level[12:11], zero[15:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], result_id[10:3], result_level[12:11],
                                   // recovered_flag[13], zero[15:14]
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    res_t          res;
    logic          out_free;
    logic          st_we, nx_we, pv_we;
    logic [IW-1:0] st_waddr, nx_waddr, nx_wdata, pv_waddr, pv_wdata, rd_addr;
    logic [IW-1:0] nx_rdata, pv_rdata;
    logic [2:0]    st_wdata, st_rdata;
    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_data_reg, m_data_next;

    assign out_free = !m_valid_reg || m_tready;

    tlpq_seq #(.NUM_ENTRIES(NUM_ENTRIES)) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tdata[2:0]),
        .in_id    (s_tdata[10:3]),
        .in_level (s_tdata[12:11]),
        .out_free (out_free),
        .res      (res),
        .st_we    (st_we),
        .st_waddr (st_waddr),
        .st_wdata (st_wdata),
        .st_rdata (st_rdata),
        .nx_we    (nx_we),
        .nx_waddr (nx_waddr),
        .nx_wdata (nx_wdata),
        .nx_rdata (nx_rdata),
        .pv_we    (pv_we),
        .pv_waddr (pv_waddr),
        .pv_wdata (pv_wdata),
        .pv_rdata (pv_rdata),
        .rd_addr  (rd_addr)
    );

    tlpq_ram #(.WIDTH(3), .DEPTH(NUM_ENTRIES)) u_state_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (rd_addr),
        .rdata (st_rdata)
    );

    tlpq_ram #(.WIDTH(IW), .DEPTH(NUM_ENTRIES)) u_next_ram (
        .aclk  (aclk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (rd_addr),
        .rdata (nx_rdata)
    );

    tlpq_ram #(.WIDTH(IW), .DEPTH(NUM_ENTRIES)) u_prev_ram (
        .aclk  (aclk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (rd_addr),
        .rdata (pv_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (res.valid) begin
            m_valid_next = 1'b1;
            m_data_next  = {2'b00, res.recovered_flag, res.result_level,
                            res.result_id, res.status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
